// ===== rtl/scr_pkg.sv =====
package scr_pkg;

	// Register indexes of the configuration port
	typedef enum logic [2:0] {
		CFG_STRIDE   = 3'd0,
		CFG_TAPS     = 3'd1,
		CFG_CHANNELS = 3'd2,
		CFG_OUTPUTS  = 3'd3,
		CFG_BIAS     = 3'd4
	} cfg_idx_t;

	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic ST_VALID = 1'b0;
	localparam logic ST_SHORT = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [2:0]         channel;
		logic [2:0]         tap;
		logic signed [15:0] value;
		logic               end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [14:0] activation;
		logic [15:0] output_index;
		logic        status;
		logic        final_res;
	} out_item_t;

	// 64-bit signed add, clamped at the type limits
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/scr_cell.sv =====
module scr_cell #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                                     clk,
	input  logic                                     shift,
	input  logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] row_in,
	output logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] row_out,
	input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_ch,
	output logic [SAMPLE_BITS-1:0]                   rd_data
);

	logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] row_q;

	// Take the neighbour's position when a new position completes
	always_ff @(posedge clk) begin
		if (shift) begin
			row_q <= row_in;
		end
	end

	assign row_out = row_q;
	assign rd_data = row_q[rd_ch];

endmodule

// ===== rtl/scr_mac.sv =====
module scr_mac #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          in_en,
	input  logic signed [SAMPLE_BITS-1:0] weight,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [15:0]            bias,
	output logic                          busy,
	output logic [14:0]                   activation
);

	logic signed [2*SAMPLE_BITS-1:0] prod_s2;
	logic                            v_s2;
	logic signed [63:0]              acc_q;
	logic signed [63:0]              biased;
	logic signed [63:0]              shifted;

	// Register the product
	always_ff @(posedge clk) begin
		prod_s2 <= weight * sample;
	end

	// Accumulate with clamping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s2 <= in_en && !clear;
			if (clear) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= scr_pkg::sat_add(acc_q, 64'(prod_s2));
			end
		end
	end

	assign busy = v_s2;

	// Add bias, apply ReLU, drop the fraction and saturate
	always_comb begin
		biased  = scr_pkg::sat_add(acc_q, 64'(bias) <<< 8);
		shifted = biased >>> 8;
		if (biased <= 64'sd0) begin
			activation = '0;
		end else if (shifted > 64'sd32767) begin
			activation = 15'h7FFF;
		end else begin
			activation = shifted[14:0];
		end
	end

endmodule

// ===== rtl/strided_conv1d_relu_unit.sv =====
// Strided multi-channel 1-D convolution, one filter, bias and ReLU. Weight loads and samples
// that do not complete an output do not hold the input. A sample that completes an output holds
// it through the issue, drain and finish states: the products go one per cycle through a
// single multiply-accumulate unit fed by the weight memory's read port and the chain of
// position cells. An end-of-data error after a valid output also passes through the error state.
// Results wait in a four-entry queue; input is taken while that queue has room for two.
module strided_conv1d_relu_unit #(
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_TAPS     = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  scr_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output scr_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int TW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNW = $clog2(MAX_CHANNELS + 1);
	localparam int TNW = $clog2(MAX_TAPS + 1);
	localparam int WD  = MAX_CHANNELS * MAX_TAPS;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

	typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DRAIN, S_FINISH, S_ERR} state_t;

	state_t state_q;

	logic [4:0]         stride_q;
	logic [3:0]         taps_q;
	logic [3:0]         chans_q;
	logic [15:0]        oc_q;
	logic signed [15:0] bias_q;

	logic [15:0]   pc_q;
	logic [15:0]   od_q;
	logic [CW-1:0] cs_q;
	logic          eod_q;
	logic [CW-1:0] cc_q;
	logic [TW-1:0] kk_q;
	logic          v_s1;

	logic [SAMPLE_BITS-1:0] wmem [WD];
	logic signed [SAMPLE_BITS-1:0] w_s1;
	logic signed [SAMPLE_BITS-1:0] s_s1;
	logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] stage_q;

	scr_pkg::out_item_t fifo_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	logic [4:0]     eff_stride;
	logic [CNW-1:0] eff_ch;
	logic [TNW-1:0] eff_taps;
	logic signed [SAMPLE_BITS-1:0] val_sb;
	logic           in_acc;
	logic           is_smp;
	logic           active;
	logic [CW:0]    cs_inc;
	logic           complete;
	logic [16:0]    pc_inc;
	logic [21:0]    need;
	logic           fire;
	logic           chain_shift;
	logic           short;
	logic [16:0]    od_inc;
	logic           pop;
	logic           push;
	scr_pkg::out_item_t push_data;
	logic [WAW-1:0] rd_addr;
	logic [TNW-1:0] sel_full;
	logic           last_issue;
	logic           mac_busy;
	logic [14:0]    act;

	logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] row_in  [MAX_TAPS];
	logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] row_out [MAX_TAPS];
	logic [SAMPLE_BITS-1:0]                   cell_rd [MAX_TAPS];

	// Effective register values
	always_comb begin
		eff_stride = (stride_q == 5'd0) ? 5'd1 : stride_q;
		if (chans_q == 4'd0) begin
			eff_ch = CNW'(1);
		end else if (int'(chans_q) > MAX_CHANNELS) begin
			eff_ch = CNW'(MAX_CHANNELS);
		end else begin
			eff_ch = CNW'(chans_q);
		end
		if (taps_q == 4'd0) begin
			eff_taps = TNW'(1);
		end else if (int'(taps_q) > MAX_TAPS) begin
			eff_taps = TNW'(MAX_TAPS);
		end else begin
			eff_taps = TNW'(taps_q);
		end
	end

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= 5'd1;
			taps_q   <= 4'd3;
			chans_q  <= 4'd3;
			oc_q     <= 16'd1;
			bias_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scr_pkg::CFG_STRIDE:   stride_q <= cfg_data[4:0];
				scr_pkg::CFG_TAPS:     taps_q   <= cfg_data[3:0];
				scr_pkg::CFG_CHANNELS: chans_q  <= cfg_data[3:0];
				scr_pkg::CFG_OUTPUTS:  oc_q     <= cfg_data;
				scr_pkg::CFG_BIAS:     bias_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode the incoming item
	assign in_stall    = !((state_q == S_IDLE) && (cnt_q <= 3'd2));
	assign in_acc      = in_valid && !in_stall;
	assign val_sb      = SAMPLE_BITS'($unsigned(in_data.value));
	assign is_smp      = (in_data.opcode == scr_pkg::OP_SAMPLE);
	assign active      = (oc_q != 16'd0) && (od_q < oc_q) && (pc_q != 16'hFFFF);
	assign cs_inc      = {1'b0, cs_q} + (CW+1)'(1);
	assign complete    = (cs_inc >= eff_ch);
	assign pc_inc      = {1'b0, pc_q} + 17'd1;
	// First position past the next output's window
	assign need        = 22'(od_q) * 22'(eff_stride) + 22'(eff_taps);
	assign fire        = (need <= 22'(pc_inc));
	assign chain_shift = in_acc && is_smp && active && complete;
	assign short       = (oc_q != 16'd0) && (od_q < oc_q);
	assign od_inc      = {1'b0, od_q} + 17'd1;

	// Weight memory: load on opcode 0, registered read while issuing
	assign rd_addr = WAW'(int'(cc_q) * MAX_TAPS + int'(kk_q));

	always_ff @(posedge clk) begin
		if (in_acc && !is_smp && (int'(in_data.channel) < MAX_CHANNELS)
				&& (int'(in_data.tap) < MAX_TAPS)) begin
			wmem[WAW'(int'(in_data.channel) * MAX_TAPS + int'(in_data.tap))] <=
				SAMPLE_BITS'(val_sb);
		end
		w_s1 <= wmem[rd_addr];
	end

	// Assemble the current position
	always_ff @(posedge clk) begin
		if (in_acc && is_smp && active) begin
			stage_q[cs_q] <= val_sb;
		end
	end

	// Chain of position cells, newest at cell 0
	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
		if (j == 0) begin : g_head
			always_comb begin
				row_in[j] = stage_q;
				row_in[j][cs_q] = val_sb;
			end
		end else begin : g_body
			assign row_in[j] = row_out[j-1];
		end
		scr_cell #(
			.MAX_CHANNELS(MAX_CHANNELS),
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk(clk),
			.shift(chain_shift),
			.row_in(row_in[j]),
			.row_out(row_out[j]),
			.rd_ch(cc_q),
			.rd_data(cell_rd[j])
		);
	end

	// Tap k sits in cell taps-1-k
	assign sel_full = eff_taps - TNW'(1) - TNW'(kk_q);

	always_ff @(posedge clk) begin
		s_s1 <= cell_rd[sel_full[TW-1:0]];
	end

	scr_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.clear(chain_shift && fire),
		.in_en(v_s1),
		.weight(w_s1),
		.sample(s_s1),
		.bias(bias_q),
		.busy(mac_busy),
		.activation(act)
	);

	assign last_issue = (CNW'(cc_q) + CNW'(1) == eff_ch) && (TNW'(kk_q) + TNW'(1) == eff_taps);

	// Result to queue
	always_comb begin
		push      = 1'b0;
		push_data = '{activation: '0, output_index: od_q, status: scr_pkg::ST_SHORT,
			final_res: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				push = in_acc && is_smp && in_data.end_of_data && short
					&& !(active && complete && fire);
			end
			S_FINISH: begin
				push = 1'b1;
				push_data = '{activation: act, output_index: od_q,
					status: scr_pkg::ST_VALID, final_res: (od_inc >= 17'(oc_q))};
			end
			S_ERR: begin
				push = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			od_q    <= '0;
			cs_q    <= '0;
			eod_q   <= 1'b0;
			cc_q    <= '0;
			kk_q    <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_ISSUE);
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && is_smp) begin
						if (active && complete && fire) begin
							cs_q    <= '0;
							pc_q    <= pc_inc[15:0];
							state_q <= S_ISSUE;
							cc_q    <= '0;
							kk_q    <= '0;
							eod_q   <= in_data.end_of_data;
						end else if (in_data.end_of_data) begin
							pc_q <= '0;
							od_q <= '0;
							cs_q <= '0;
						end else if (active) begin
							if (complete) begin
								cs_q <= '0;
								pc_q <= pc_inc[15:0];
							end else begin
								cs_q <= cs_inc[CW-1:0];
							end
						end
					end
				end
				S_ISSUE: begin
					if (last_issue) begin
						state_q <= S_DRAIN;
					end else if (TNW'(kk_q) + TNW'(1) == eff_taps) begin
						kk_q <= '0;
						cc_q <= cc_q + CW'(1);
					end else begin
						kk_q <= kk_q + TW'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !mac_busy) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (eod_q && (od_inc < 17'(oc_q))) begin
						od_q    <= od_inc[15:0];
						state_q <= S_ERR;
					end else if (eod_q) begin
						pc_q    <= '0;
						od_q    <= '0;
						cs_q    <= '0;
						state_q <= S_IDLE;
					end else begin
						od_q    <= od_inc[15:0];
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					pc_q    <= '0;
					od_q    <= '0;
					cs_q    <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result queue
	assign out_valid = (cnt_q != 3'd0);
	assign out_data  = fifo_q[rd_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 80;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	scr_pkg::in_item_t   in_data;
	logic                out_valid;
	logic                out_stall;
	scr_pkg::out_item_t  out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [2:0]          cfg_index;
	logic [15:0]         cfg_data;

	strided_conv1d_relu_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow state of the convolution
	int        weight_mem [64];
	int        window_mem [64];
	int        pos_cnt, done_cnt, chan_cnt;
	int        reg_stride, reg_taps, reg_chans, reg_count;
	int        reg_bias;

	scr_pkg::out_item_t expected_acts [$];
	int        errors;
	int        n_results, n_short, n_items;
	int        cycles;
	int        burst_left;
	bit        no_gaps;
	bit        hold_req;

	// Directed stimulus table
	typedef struct {
		scr_pkg::in_item_t  item;
		int                 n_typed;
		scr_pkg::out_item_t r0;
		scr_pkg::out_item_t r1;
	} dir_row_t;

	dir_row_t dir_rows [$];

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int clamp_range(int v, int hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// Work out the activations caused by one transfer
	task automatic predict_acts(input scr_pkg::in_item_t it);
		int                 es, et, ec, base, c, k;
		longint             acc;
		longint             act;
		scr_pkg::out_item_t r;
		es = (reg_stride == 0) ? 1 : reg_stride;
		et = clamp_range(reg_taps, 8);
		ec = clamp_range(reg_chans, 8);
		if (it.opcode == scr_pkg::OP_WEIGHT) begin
			weight_mem[it.channel * 8 + it.tap] = it.value;
		end else begin
			if (reg_count != 0 && done_cnt < reg_count && pos_cnt < 65535) begin
				window_mem[(pos_cnt % 8) * 8 + chan_cnt] = it.value;
				chan_cnt++;
				if (chan_cnt >= ec) begin
					chan_cnt = 0;
					pos_cnt++;
					if (done_cnt * es + et <= pos_cnt) begin
						base = pos_cnt - et;
						acc = 0;
						for (c = 0; c < ec; c++)
							for (k = 0; k < et; k++)
								acc += longint'(weight_mem[c * 8 + k]) *
									longint'(window_mem[((base + k) % 8) * 8 + c]);
						acc += longint'(reg_bias) * 256;
						if (acc <= 0)
							act = 0;
						else begin
							act = acc >>> 8;
							if (act > 32767)
								act = 32767;
						end
						r.activation   = act[14:0];
						r.output_index = done_cnt[15:0];
						r.status       = scr_pkg::ST_VALID;
						done_cnt++;
						r.final_res    = (done_cnt >= reg_count);
						expected_acts.push_back(r);
					end
				end
			end
			if (it.end_of_data) begin
				if (reg_count != 0 && done_cnt < reg_count) begin
					r.activation   = '0;
					r.output_index = done_cnt[15:0];
					r.status       = scr_pkg::ST_SHORT;
					r.final_res    = 1'b1;
					expected_acts.push_back(r);
				end
				pos_cnt  = 0;
				done_cnt = 0;
				chan_cnt = 0;
			end
		end
	endtask

	// Offer one item and hold it until the transfer
	task automatic send_item(input scr_pkg::in_item_t it);
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_stall);
		n_items++;
		if (burst_left > 0)
			burst_left--;
		else if (!no_gaps) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
		end
	endtask

	// Drain every activation and let the block go idle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_acts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Hold one register write until the transfer; the caller drops valid
	task automatic cfg_write(input scr_pkg::cfg_idx_t idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[15:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			scr_pkg::CFG_STRIDE:   reg_stride = val & 32'h1f;
			scr_pkg::CFG_TAPS:     reg_taps   = val & 32'hf;
			scr_pkg::CFG_CHANNELS: reg_chans  = val & 32'hf;
			scr_pkg::CFG_OUTPUTS:  reg_count  = val & 32'hffff;
			scr_pkg::CFG_BIAS:     reg_bias   = $signed(val[15:0]);
			default: ;
		endcase
	endtask

	task automatic set_layer(input int st, input int tp, input int ch, input int cnt,
		input int bs);
		wait_idle();
		cfg_write(scr_pkg::CFG_STRIDE, st);
		cfg_write(scr_pkg::CFG_TAPS, tp);
		cfg_write(scr_pkg::CFG_CHANNELS, ch);
		cfg_write(scr_pkg::CFG_OUTPUTS, cnt);
		cfg_write(scr_pkg::CFG_BIAS, bs);
		cfg_valid <= 1'b0;
	endtask

	function automatic scr_pkg::in_item_t make_item(input logic op, input int val,
		input logic eod);
		scr_pkg::in_item_t it;
		it.opcode      = op;
		it.channel     = 3'($urandom_range(0, 7));
		it.tap         = 3'($urandom_range(0, 7));
		it.value       = val[15:0];
		it.end_of_data = eod;
		return it;
	endfunction

	function automatic int rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 65535);
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return int'($urandom_range(0, 1023)) - 512;
		endcase
	endfunction

	// Reload the weights that the current layer settings reach
	task automatic load_weights(input bit wide);
		scr_pkg::in_item_t it;
		int                c, k, et, ec;
		et = clamp_range(reg_taps, 8);
		ec = clamp_range(reg_chans, 8);
		for (c = 0; c < ec; c++)
			for (k = 0; k < et; k++) begin
				it = make_item(scr_pkg::OP_WEIGHT, wide ? rand_value() :
					int'($urandom_range(0, 511)) - 256, 1'($urandom_range(0, 1)));
				it.channel = 3'(c);
				it.tap     = 3'(k);
				predict_acts(it);
				send_item(it);
			end
	endtask

	// One input sequence, mostly well formed, sometimes cut short or overlong
	task automatic send_sequence();
		int                es, et, ec, npos, p, c;
		scr_pkg::in_item_t it;
		es = (reg_stride == 0) ? 1 : reg_stride;
		et = clamp_range(reg_taps, 8);
		ec = clamp_range(reg_chans, 8);
		npos = ((reg_count == 0 ? 1 : reg_count) - 1) * es + et;
		if ($urandom_range(0, 3) == 0)
			npos = npos + int'($urandom_range(0, 6)) - 3;
		if (npos < 1)
			npos = 1;
		for (p = 0; p < npos; p++)
			for (c = 0; c < ec; c++) begin
				if ($urandom_range(0, 19) == 0) begin
					it = make_item(scr_pkg::OP_WEIGHT, rand_value(),
						1'($urandom_range(0, 1)));
					it.channel = 3'($urandom_range(0, ec - 1));
					it.tap     = 3'($urandom_range(0, et - 1));
					predict_acts(it);
					send_item(it);
				end
				it = make_item(scr_pkg::OP_SAMPLE, rand_value(),
					(p == npos - 1 && c == ec - 1) || $urandom_range(0, 199) == 0);
				predict_acts(it);
				send_item(it);
				if (it.end_of_data)
					return;
			end
		// Close with an extra end marker on a coin toss
		if ($urandom_range(0, 1) == 0) begin
			it = make_item(scr_pkg::OP_SAMPLE, rand_value(), 1'b1);
			predict_acts(it);
			send_item(it);
		end
	endtask

	task automatic add_row(input scr_pkg::in_item_t it, input int n,
		input scr_pkg::out_item_t a, input scr_pkg::out_item_t b);
		dir_row_t row;
		row.item    = it;
		row.n_typed = n;
		row.r0      = a;
		row.r1      = b;
		dir_rows.push_back(row);
	endtask

	// Receiver: stall pattern of its own, plus one long hold-off on request
	initial begin
		int mode;
		out_stall = 1'b0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (500) @(posedge clk);
			end
			if (cycles % 97 == 0)
				mode = $urandom_range(0, 2);
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Compare each transfer with the oldest expectation
	always @(posedge clk) begin
		scr_pkg::out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_acts.size() == 0) begin
				$error("unexpected result: %p", out_data);
				errors++;
			end else begin
				e = expected_acts.pop_front();
				n_results++;
				if (e.status == scr_pkg::ST_SHORT)
					n_short++;
				if (out_data.activation !== e.activation) begin
					$error("activation: expected %0d, actual %0d", e.activation,
						out_data.activation);
					errors++;
				end
				if (out_data.output_index !== e.output_index) begin
					$error("output_index: expected %0d, actual %0d", e.output_index,
						out_data.output_index);
					errors++;
				end
				if (out_data.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, out_data.status);
					errors++;
				end
				if (out_data.final_res !== e.final_res) begin
					$error("final_res: expected %0d, actual %0d", e.final_res,
						out_data.final_res);
					errors++;
				end
			end
		end
	end

	initial begin
		scr_pkg::in_item_t  it;
		scr_pkg::out_item_t ra, rb, none;
		int                 i, n, ph, wait_cnt;
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		errors     = 0;
		n_results  = 0;
		n_short    = 0;
		n_items    = 0;
		cycles     = 0;
		burst_left = 0;
		no_gaps    = 1'b0;
		hold_req   = 1'b0;
		pos_cnt    = 0;
		done_cnt   = 0;
		chan_cnt   = 0;
		reg_stride = 1;
		reg_taps   = 3;
		reg_chans  = 3;
		reg_count  = 1;
		reg_bias   = 0;
		none       = '0;
		rb         = '0;
		foreach (weight_mem[j]) weight_mem[j] = 0;
		foreach (window_mem[j]) window_mem[j] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Unit weights under the reset layer settings
		for (i = 0; i < 64; i++) begin
			it = make_item(scr_pkg::OP_WEIGHT, 256, 1'b0);
			it.channel = 3'(i / 8);
			it.tap     = 3'(i % 8);
			predict_acts(it);
			send_item(it);
		end

		// Full-scale window saturates; one lone end marker is too short
		for (i = 0; i < 8; i++)
			add_row(make_item(scr_pkg::OP_SAMPLE, 32767, 1'b0), 0, none, none);
		ra = '{activation: 15'd32767, output_index: 16'd0, status: scr_pkg::ST_VALID,
			final_res: 1'b1};
		add_row(make_item(scr_pkg::OP_SAMPLE, 32767, 1'b0), 1, ra, none);
		add_row(make_item(scr_pkg::OP_SAMPLE, 32767, 1'b1), 0, none, none);
		ra = '{activation: 15'd0, output_index: 16'd0, status: scr_pkg::ST_SHORT,
			final_res: 1'b1};
		add_row(make_item(scr_pkg::OP_SAMPLE, 5, 1'b1), 1, ra, none);
		// Most negative samples clip to zero; marker after the output is silent
		for (i = 0; i < 8; i++)
			add_row(make_item(scr_pkg::OP_SAMPLE, -32768, 1'b0), 0, none, none);
		ra = '{activation: 15'd0, output_index: 16'd0, status: scr_pkg::ST_VALID,
			final_res: 1'b1};
		add_row(make_item(scr_pkg::OP_SAMPLE, -32768, 1'b0), 1, ra, none);
		add_row(make_item(scr_pkg::OP_SAMPLE, 1000, 1'b1), 0, none, none);
		// Weight load with end marker set, then a mixed window
		add_row(make_item(scr_pkg::OP_WEIGHT, -32768, 1'b1), -1, none, none);
		for (i = 0; i < 9; i++)
			add_row(make_item(scr_pkg::OP_SAMPLE, rand_value(), i == 8), -1, none, none);

		foreach (dir_rows[j]) begin
			n = expected_acts.size();
			predict_acts(dir_rows[j].item);
			if (dir_rows[j].n_typed >= 0) begin
				while (expected_acts.size() > n)
					void'(expected_acts.pop_back());
				if (dir_rows[j].n_typed > 0)
					expected_acts.push_back(dir_rows[j].r0);
				if (dir_rows[j].n_typed > 1)
					expected_acts.push_back(dir_rows[j].r1);
			end
			send_item(dir_rows[j].item);
		end

		// Random phases over a spread of layer settings
		for (ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_layer(1, 3, 3, 6, 0);
				1: set_layer(16, 8, 8, 2, -32768);
				2: set_layer(1, 1, 1, 40, 32767);
				3: set_layer(0, 15, 0, 4, rand_value());
				4: set_layer(31, 2, 4, 2, rand_value());
				5: set_layer(0, 0, 15, 3, rand_value());
				6: set_layer(0, 1, 1, 0, rand_value());
				default: set_layer($urandom_range(1, 4), $urandom_range(1, 8),
					$urandom_range(1, 4), $urandom_range(1, 4), rand_value());
			endcase
			load_weights(1'(ph % 2));
			if (ph == 2)
				hold_req = 1'b1;
			n = n_items;
			while (n_items - n < 20)
				send_sequence();
		end

		in_valid <= 1'b0;
		wait_cnt = 0;
		while (expected_acts.size() != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d transfers in, %0d results out (%0d short-input errors),",
			n_items, n_results, n_short);
		$display("over extreme and clamped layer settings and a long output hold-off.");
		if (errors == 0 && expected_acts.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
